[design/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[design/cfa_pkg.sv]
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and constants for the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;
	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;
	localparam logic       ACT_ADD    = 1'b0;
	localparam logic       ACT_REMOVE = 1'b1;
	localparam logic [0:0] REG_FIT_MODE  = 1'b0;
	localparam logic [0:0] REG_MOVE_TIME = 1'b1;
	localparam logic [15:0] MOVE_TIME_RESET = 16'd10;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_REMOVE, ST_SCAN, ST_SCAN_END, ST_CPT_INIT, ST_CPT,
		ST_MUL, ST_FILL_INIT, ST_FILL, ST_OUT
	} cfa_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture input item
		logic clr_step;   // clear sweep
		logic rem_step;   // remove sweep
		logic scan_init;
		logic scan_step;
		logic cpt_init;
		logic cpt_step;
		logic mul;        // latch time result
		logic fill_init;
		logic fill_step;
	} cfa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sweep_done;  // pointer reached the last cell, or the fill count ran out
		logic is_add;
		logic add_ok;      // add arguments valid
		logic found;
		logic older;
		logic compacted;
	} cfa_sts_t;
endpackage

[design/cfa_ctrl.sv]
// ----------------------------------------------------------------------------
// cfa_ctrl
// Sequencer for clear, remove, scan, compaction and fill sweeps.
// ----------------------------------------------------------------------------
module cfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cfa_pkg::cfa_sts_t sts,
	output cfa_pkg::cfa_cmd_t cmd
);
	import cfa_pkg::*;

	cfa_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: if (sts.sweep_done) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_SCAN_END;
			ST_SCAN_END: begin
				// decode freshly loaded item
				if (!sts.is_add) state_d = ST_REMOVE;
				else if (!sts.add_ok) state_d = ST_OUT;
				else state_d = ST_SCAN;
			end
			ST_REMOVE: if (sts.sweep_done) state_d = ST_OUT;
			ST_SCAN: begin
				if (sts.sweep_done) begin
					if (sts.found) state_d = ST_FILL_INIT;
					else if (sts.older && !sts.compacted) state_d = ST_CPT_INIT;
					else state_d = ST_OUT;
				end
			end
			ST_CPT_INIT: state_d = ST_CPT;
			ST_CPT: if (sts.sweep_done) state_d = ST_MUL;
			ST_MUL: state_d = ST_SCAN;
			ST_FILL_INIT: state_d = ST_FILL;
			ST_FILL: if (sts.sweep_done) state_d = ST_OUT;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_CLR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN_END: cmd.scan_init = 1'b1;
			ST_REMOVE: cmd.rem_step = 1'b1;
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_CPT_INIT: cmd.cpt_init = 1'b1;
			ST_CPT: cmd.cpt_step = 1'b1;
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.scan_init = 1'b1;
			end
			// pick is settled in the cycle after the scan ends
			ST_FILL_INIT: cmd.fill_init = 1'b1;
			ST_FILL: cmd.fill_step = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

[design/cfa_dp.sv]
// ----------------------------------------------------------------------------
// cfa_dp
// Cell store, run scanner, compactor and result registers.
// ----------------------------------------------------------------------------
module cfa_dp #(
	parameter int CELL_COUNT = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfa_pkg::cfa_cmd_t cmd,
	output cfa_pkg::cfa_sts_t sts,
	input  logic              cfg_we,
	input  logic              cfg_idx,
	input  logic [15:0]       cfg_data,
	input  logic              in_action,
	input  logic [7:0]        in_owner,
	input  logic [8:0]        in_size,
	input  logic [31:0]       in_start,
	input  logic [31:0]       in_lct,
	input  logic [31:0]       in_llt,
	output logic [83:0]       res
);
	import cfa_pkg::*;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CW = AW + 1;

	logic [7:0] mem [CELL_COUNT];
	logic [7:0]  rd_q;
	logic [1:0]  fit_mode_q;
	logic [15:0] move_time_q;
	logic        act_q;
	logic [7:0]  owner_q;
	logic [8:0]  size_q;
	logic [31:0] start_q, lct_q, llt_q;
	logic [1:0]  mode_q;
	logic [CW-1:0] nfp_q;

	// scan state; each sweep pointer walks one cell per cycle
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] wptr_q;
	logic [CW-1:0] run_start_q, run_len_q;
	logic          found_q, pick_hi_q;
	logic [CW-1:0] pick_q, pick_len_q;
	logic          removed_q, compacted_q, placed_q;
	logic [CW-1:0] moved_q;
	logic [31:0]   fin_time_q;
	logic [CW-1:0] fill_cnt_q;
	logic [8:0]    moved_sat;

	// store data is registered from the next pointer, so cur is the cell at the pointer
	logic [7:0] cur;
	assign cur = rd_q;
	wire last = (ptr_q == AW'(CELL_COUNT - 1));

	always_comb begin
		ptr_d = ptr_q;
		if (cmd.clr_step || cmd.rem_step || cmd.scan_step || cmd.cpt_step)
			ptr_d = last ? '0 : ptr_q + 1'b1;
		if (cmd.scan_init || cmd.cpt_init) ptr_d = '0;
		if (cmd.fill_init) ptr_d = pick_q[AW-1:0];
		if (cmd.fill_step) ptr_d = ptr_q + 1'b1;
	end

	// a run closes at an occupied cell or at the end of the store
	logic          is_free, closes;
	logic [CW-1:0] len_now, start_now;
	always_comb begin
		is_free = (cur == 8'd0);
		len_now = is_free ? run_len_q + 1'b1 : run_len_q;
		start_now = (run_len_q == '0) ? {1'b0, ptr_q} : run_start_q;
		closes = !is_free || last;
		if (!is_free) start_now = run_start_q;
	end
	wire fits = closes && (len_now != '0) && (32'(size_q) <= 32'(len_now));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
			move_time_q <= MOVE_TIME_RESET;
			nfp_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_FIT_MODE) fit_mode_q <= cfg_data[1:0];
				else move_time_q <= cfg_data;
			end
			ptr_q <= ptr_d;
			if (cmd.cpt_init && mode_q == FIT_NEXT) nfp_q <= '0;
			if (cmd.fill_step && fill_cnt_q == CW'(1) && mode_q == FIT_NEXT)
				nfp_q <= CW'(pick_q + size_q);
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[ptr_d];
		if (cmd.clr_step) mem[ptr_q] <= 8'd0;
		if (cmd.rem_step && cur == owner_q && owner_q != 8'd0) begin
			mem[ptr_q] <= 8'd0;
			removed_q <= 1'b1;
		end
		if (cmd.load) begin
			act_q <= in_action; owner_q <= in_owner; size_q <= in_size;
			start_q <= in_start; lct_q <= in_lct; llt_q <= in_llt;
			mode_q <= (fit_mode_q == FIT_NEXT || fit_mode_q == FIT_BEST) ?
				fit_mode_q : FIT_FIRST;
			removed_q <= 1'b0; compacted_q <= 1'b0; placed_q <= 1'b0;
			moved_q <= '0; fin_time_q <= in_start;
		end
		if (cmd.scan_init) begin
			run_len_q <= '0; run_start_q <= '0;
			found_q <= 1'b0; pick_hi_q <= 1'b0;
			pick_q <= '0; pick_len_q <= '0;
		end
		if (cmd.scan_step) begin
			if (is_free) begin
				run_len_q <= len_now;
				run_start_q <= start_now;
			end else run_len_q <= '0;
			if (fits && !pick_hi_q) begin
				case (mode_q)
					FIT_NEXT: begin
						if (!found_q || start_now >= nfp_q) pick_q <= start_now;
						if (start_now >= nfp_q) pick_hi_q <= 1'b1;
					end
					FIT_BEST: begin
						if (!found_q || len_now < pick_len_q) begin
							pick_q <= start_now; pick_len_q <= len_now;
						end
					end
					default: begin
						pick_q <= start_now; pick_hi_q <= 1'b1;
					end
				endcase
				found_q <= 1'b1;
			end
		end
		if (cmd.cpt_init) begin
			wptr_q <= '0; moved_q <= '0; compacted_q <= 1'b1;
		end
		if (cmd.cpt_step && cur != 8'd0) begin
			// cells below the first hole stay in place
			if (wptr_q != ptr_q) begin
				mem[ptr_q] <= 8'd0;
				mem[wptr_q] <= cur;
				moved_q <= moved_q + 1'b1;
			end
			wptr_q <= wptr_q + 1'b1;
		end
		if (cmd.mul) begin
			fin_time_q <= start_q + 32'(moved_q) * 32'(move_time_q);
			lct_q <= start_q + 32'(moved_q) * 32'(move_time_q);
		end
		if (cmd.fill_init) begin
			fill_cnt_q <= CW'(size_q);
			placed_q <= found_q;
		end
		if (cmd.fill_step) begin
			mem[ptr_q] <= owner_q;
			fill_cnt_q <= fill_cnt_q - 1'b1;
		end
	end

	always_comb begin
		sts.sweep_done = cmd.fill_step ? (fill_cnt_q == CW'(1)) : last;
		sts.is_add = (act_q == ACT_ADD);
		sts.add_ok = (owner_q != 8'd0) && (size_q != 9'd0);
		sts.found = found_q || fits;
		sts.older = $signed(lct_q) < $signed(llt_q);
		sts.compacted = compacted_q;
	end

	// move count saturates at the field width on a wide store
	assign moved_sat = (32'(moved_q) > 32'd511) ? 9'h1FF : 9'(moved_q);

	assign res = {lct_q, fin_time_q, moved_sat, compacted_q,
		placed_q ? 8'(pick_q) : 8'd0, removed_q && !sts.is_add, placed_q};
endmodule

[design/contiguous_fit_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Owner-tag cell store with first, next and best fit and compaction.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      request item
// m_axis   out  tvalid/tready      result item
// cfg      in   cfg_valid/ready    register index and data
// After reset a clear sweep zeroes every cell before items are taken.
// Remove clears the owner's cells in one sweep. Add scans for a run; if none fits
// and last_compact_time is before last_leave_time, it compacts and rescans once;
// a found run is then filled with request_size cells.
// One item is in work at a time; a new request is taken only after the result is handed over.
module contiguous_fit_allocator #(
	parameter int CELL_COUNT = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action, owner_id, request_size, arrival time, last_compact_time,
	// last_leave_time, zero pad
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// placed, removed, base_address, compacted, cells_moved, finish time,
	// updated_compact_time, zero pad
	output logic [87:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [15:0]  cfg_data
);
	import cfa_pkg::*;
	`include "assert_macros.svh"

	cfa_cmd_t   cmd;
	cfa_sts_t   sts;
	logic [83:0] res;

	assign cfg_ready = 1'b1;

	cfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	cfa_dp #(.CELL_COUNT(CELL_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.in_action(s_axis_tdata[0]), .in_owner(s_axis_tdata[8:1]),
		.in_size(s_axis_tdata[17:9]), .in_start(s_axis_tdata[49:18]),
		.in_lct(s_axis_tdata[81:50]), .in_llt(s_axis_tdata[113:82]),
		.res(res)
	);

	assign m_axis_tdata = {4'd0, res};

	`ASSERT_CLK(a_no_overlap, clk, arst_n, !(s_axis_tready && m_axis_tvalid), "ready during output")
	`ASSERT_CLK(a_one_cmd, clk, arst_n, $onehot0({cmd.clr_step, cmd.rem_step, cmd.scan_step, cmd.cpt_step, cmd.fill_step}), "sweep overlap")
	`ASSERT_CLK(a_placed_excl, clk, arst_n, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]), "placed and removed")
endmodule
